// ===== rtl/core/kvcs_pkg.sv =====
// ----------------------------------------------------------------------------
// kvcs_pkg
// Shared constants, result kinds and controller/datapath interface types for
// the key/value configuration scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package kvcs_pkg;

	// Sizing
	localparam int TABLE_DEPTH  = 64;
	localparam int OFFSET_WIDTH = 16;
	localparam int HASH_WIDTH   = 32;
	localparam int ADDR_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);

	// Result field widths on the output word
	localparam int KIND_W    = 3;
	localparam int OUT_HASH_W = 32;
	localparam int OUT_OFF_W = 16;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_ENTRY   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_END     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_COMMENT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_NOVAL   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_DUP     = 3'd4;
	localparam logic [KIND_W-1:0] KIND_FULL    = 3'd5;

	// Character codes
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// djb2 start value and its first step folded
	localparam logic [HASH_WIDTH-1:0] HASH_INIT    = HASH_WIDTH'(5381);
	localparam logic [HASH_WIDTH-1:0] HASH_INIT_33 = HASH_WIDTH'(5381 * 33);

	// Controller to datapath commands
	typedef struct packed {
		logic load;      // capture the input word
		logic parse;     // run the byte parser and latch the pending result
		logic idx_clr;   // restart the table scan
		logic idx_inc;   // advance the table scan
		logic set_dup;   // mark pending entry as duplicate
		logic resolve;   // store entry or mark table full
		logic emit;      // move pending result to the output register
	} kvcs_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic done;       // byte completes an entry
		logic has_result; // byte produces some result
		logic count_zero; // table is empty
		logic match;      // table word equals pending hash
		logic last_idx;   // scan index is the last stored entry
		logic out_free;   // output register can take a word
	} kvcs_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/kvcs_ram.sv =====
// ----------------------------------------------------------------------------
// kvcs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kvcs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/kvcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// kvcs_ctrl
// Sequencer: accept a word, parse it, scan the hash table on a finished
// entry, then hand the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kvcs_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire kvcs_pkg::kvcs_sts_t sts,
	output kvcs_pkg::kvcs_cmd_t      cmd
);

	import kvcs_pkg::*;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_PARSE   = 3'd1;
	localparam logic [2:0] S_READ    = 3'd2;
	localparam logic [2:0] S_CMP     = 3'd3;
	localparam logic [2:0] S_RESOLVE = 3'd4;
	localparam logic [2:0] S_EMIT    = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = S_PARSE;
				end
			end
			S_PARSE: begin
				cmd.parse = 1'b1;
				if (sts.done) begin
					cmd.idx_clr = 1'b1;
					state_nx    = sts.count_zero ? S_RESOLVE : S_READ;
				end else if (sts.has_result) begin
					state_nx = S_EMIT;
				end else begin
					state_nx = S_IDLE;
				end
			end
			S_READ: begin
				state_nx = S_CMP;
			end
			S_CMP: begin
				if (sts.match) begin
					cmd.set_dup = 1'b1;
					state_nx    = S_EMIT;
				end else if (sts.last_idx) begin
					state_nx = S_RESOLVE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_nx    = S_READ;
				end
			end
			S_RESOLVE: begin
				cmd.resolve = 1'b1;
				state_nx    = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/kvcs_datapath.sv =====
// ----------------------------------------------------------------------------
// kvcs_datapath
// Byte parser, djb2 hash, hash table with scan index, pending result and
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kvcs_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire kvcs_pkg::kvcs_cmd_t         cmd,
	output kvcs_pkg::kvcs_sts_t              sts,
	input  wire logic [7:0]                  in_byte,
	input  wire logic                        in_fin,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [kvcs_pkg::KIND_W-1:0]      out_kind,
	output logic [kvcs_pkg::OUT_HASH_W-1:0]  out_hash,
	output logic [kvcs_pkg::OUT_OFF_W-1:0]   out_vbegin,
	output logic [kvcs_pkg::OUT_OFF_W-1:0]   out_vfinish,
	output logic                             out_quoted,
	output logic [kvcs_pkg::OUT_OFF_W-1:0]   out_offset,
	output logic                             out_last
);

	import kvcs_pkg::*;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_NAME  = 2'd1;
	localparam logic [1:0] PH_GAP   = 2'd2;
	localparam logic [1:0] PH_VALUE = 2'd3;

	// Input word register
	logic [7:0] byte_q;
	logic       fin_q;

	// Parser state
	logic [1:0]              phase_q;
	logic                    in_comment_q;
	logic                    in_quotes_q;
	logic                    failed_q;
	logic [HASH_WIDTH-1:0]   hash_q;
	logic [OFFSET_WIDTH-1:0] vstart_q;
	logic [OFFSET_WIDTH-1:0] pos_q;
	logic [7:0]              prev_q;
	logic [7:0]              prev2_q;

	// Table control
	logic [CNT_W-1:0]      count_q;
	logic [ADDR_W-1:0]     idx_q;
	logic [HASH_WIDTH-1:0] tbl_rdata;
	logic                  tbl_we;

	// Pending result
	logic [KIND_W-1:0]       pend_kind_q;
	logic [HASH_WIDTH-1:0]   pend_hash_q;
	logic [OFFSET_WIDTH-1:0] pend_vb_q;
	logic [OFFSET_WIDTH-1:0] pend_vf_q;
	logic                    pend_quo_q;
	logic [OFFSET_WIDTH-1:0] pend_off_q;
	logic                    pend_fin_q;

	// Output register
	logic out_vld_q;

	// Parser next values
	logic [1:0]              nx_phase;
	logic                    nx_com;
	logic                    nx_quo;
	logic [HASH_WIDTH-1:0]   nx_hash;
	logic [OFFSET_WIDTH-1:0] nx_vst;
	logic [OFFSET_WIDTH-1:0] pos_inc;
	logic [OFFSET_WIDTH-1:0] vend;
	logic                    done;
	logic                    err;
	logic [KIND_W-1:0]       err_kind;
	logic                    full;

	assign pos_inc = pos_q + OFFSET_WIDTH'(1);
	assign full    = (count_q == CNT_W'(TABLE_DEPTH));

	// Parse the captured byte against the current scan state
	always_comb begin
		nx_phase = phase_q;
		nx_com   = in_comment_q;
		nx_quo   = in_quotes_q;
		nx_hash  = hash_q;
		nx_vst   = vstart_q;
		vend     = '0;
		done     = 1'b0;
		err      = 1'b0;
		err_kind = KIND_COMMENT;
		if (!failed_q) begin
			if (in_comment_q) begin
				if (byte_q == CH_NL) begin
					nx_com = 1'b0;
				end
			end else if (byte_q == CH_HASH && !in_quotes_q) begin
				if (phase_q == PH_NAME || phase_q == PH_GAP) begin
					err      = 1'b1;
					err_kind = KIND_COMMENT;
				end else if (phase_q == PH_VALUE) begin
					vend = pos_q;
					done = 1'b1;
				end
				nx_com = 1'b1;
			end else begin
				case (phase_q)
					PH_IDLE: begin
						if (byte_q != CH_SPACE && byte_q != CH_NL) begin
							nx_hash  = HASH_INIT_33 + HASH_WIDTH'(byte_q);
							nx_phase = PH_NAME;
						end
					end
					PH_NAME: begin
						if (byte_q == CH_SPACE || byte_q == CH_EQ) begin
							nx_phase = PH_GAP;
						end else begin
							nx_hash = (hash_q << 5) + hash_q + HASH_WIDTH'(byte_q);
						end
					end
					PH_GAP: begin
						if (byte_q == CH_NL) begin
							err      = 1'b1;
							err_kind = KIND_NOVAL;
						end else if (byte_q != CH_SPACE && byte_q != CH_EQ) begin
							nx_phase = PH_VALUE;
							if (byte_q == CH_QUOTE) begin
								nx_quo = 1'b1;
								nx_vst = pos_inc;
							end else begin
								nx_vst = pos_q;
								if (fin_q) begin
									vend = pos_inc;
									done = 1'b1;
								end
							end
						end
					end
					default: begin
						if (!in_quotes_q) begin
							if (byte_q == CH_NL) begin
								vend = pos_q;
								done = 1'b1;
							end else if (fin_q) begin
								vend = pos_inc;
								done = 1'b1;
							end
						end else if (byte_q == CH_QUOTE &&
								(prev_q != CH_BSL || prev2_q == CH_BSL)) begin
							vend   = pos_q;
							done   = 1'b1;
							nx_com = 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Capture the input word
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= in_byte;
			fin_q  <= in_fin;
		end
	end

	// Parser state: advance on parse, clear at end of text, set failed on a duplicate or full table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			in_comment_q <= 1'b0;
			in_quotes_q  <= 1'b0;
			failed_q     <= 1'b0;
			hash_q       <= HASH_INIT;
			vstart_q     <= '0;
			pos_q        <= '0;
			prev_q       <= '0;
			prev2_q      <= '0;
		end else if (cmd.emit && pend_fin_q) begin
			phase_q      <= PH_IDLE;
			in_comment_q <= 1'b0;
			in_quotes_q  <= 1'b0;
			failed_q     <= 1'b0;
			hash_q       <= HASH_INIT;
			vstart_q     <= '0;
			pos_q        <= '0;
			prev_q       <= '0;
			prev2_q      <= '0;
		end else if (cmd.parse) begin
			phase_q      <= done ? PH_IDLE : nx_phase;
			in_comment_q <= nx_com;
			in_quotes_q  <= done ? 1'b0 : nx_quo;
			hash_q       <= done ? HASH_INIT : nx_hash;
			vstart_q     <= done ? '0 : nx_vst;
			failed_q     <= failed_q | err;
			pos_q        <= pos_inc;
			prev_q       <= byte_q;
			prev2_q      <= prev_q;
		end else if (cmd.set_dup || (cmd.resolve && full)) begin
			failed_q <= 1'b1;
		end
	end

	// Table fill count and scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.emit && pend_fin_q) begin
				count_q <= '0;
			end else if (tbl_we) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + ADDR_W'(1);
			end
		end
	end

	assign tbl_we = cmd.resolve && !full;

	kvcs_ram #(
		.WIDTH (HASH_WIDTH),
		.DEPTH (TABLE_DEPTH),
		.AW    (ADDR_W)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (count_q[ADDR_W-1:0]),
		.wdata (pend_hash_q),
		.raddr (idx_q),
		.rdata (tbl_rdata)
	);

	// Pending result: latch on parse, refine kind after the table scan
	always_ff @(posedge clk) begin
		if (cmd.parse) begin
			pend_off_q <= pos_q;
			pend_fin_q <= fin_q;
			if (err) begin
				pend_kind_q <= err_kind;
				pend_hash_q <= hash_q;
				pend_vb_q   <= '0;
				pend_vf_q   <= '0;
				pend_quo_q  <= 1'b0;
			end else if (done) begin
				pend_kind_q <= KIND_ENTRY;
				pend_hash_q <= hash_q;
				pend_vb_q   <= nx_vst;
				pend_vf_q   <= vend;
				pend_quo_q  <= nx_quo;
			end else begin
				pend_kind_q <= KIND_END;
				pend_hash_q <= '0;
				pend_vb_q   <= '0;
				pend_vf_q   <= '0;
				pend_quo_q  <= 1'b0;
			end
		end else if (cmd.set_dup) begin
			pend_kind_q <= KIND_DUP;
		end else if (cmd.resolve) begin
			pend_kind_q <= full ? KIND_FULL : KIND_ENTRY;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind    <= pend_kind_q;
			out_hash    <= OUT_HASH_W'(pend_hash_q);
			out_vbegin  <= OUT_OFF_W'(pend_vb_q);
			out_vfinish <= OUT_OFF_W'(pend_vf_q);
			out_quoted  <= pend_quo_q;
			out_offset  <= OUT_OFF_W'(pend_off_q);
			out_last    <= pend_fin_q;
		end
	end

	assign out_valid = out_vld_q;

	// Status to the controller
	assign sts.done       = done;
	assign sts.has_result = done | err | fin_q;
	assign sts.count_zero = (count_q == '0);
	assign sts.match      = (tbl_rdata == pend_hash_q);
	assign sts.last_idx   = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
	assign sts.out_free   = !out_vld_q || out_ready;

endmodule

`default_nettype wire

// ===== rtl/core/key_value_config_scanner.sv =====
// ----------------------------------------------------------------------------
// key_value_config_scanner
// Scans configuration text one byte per word, hashes entry names with djb2,
// checks each finished entry against a table of stored name hashes and
// reports entries, errors and end of text.
//
//   Channel | Dir | tdata                      | tuser          | tlast
//   s_axis  | in  | text_byte[7:0]             | -              | final_byte
//   m_axis  | out | name_hash, value_head,     | result_kind    | at_text_end
//           |     | value_finish, quoted_value,|                |
//           |     | event_offset               |                |
//
// A byte that gives no result is accepted and parsed. A finished entry then
// scans the stored hashes (RAM read, compare for each), stores or refuses
// the hash unless a duplicate ends the scan at its match, and moves into the
// output register; errors and end of text go straight to the output register.
// A waiting result holds the sequencer only when the next result is ready.
// Reset and the final byte clear the parser and the table fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_config_scanner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  wire logic        s_axis_tlast,   // final_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [87:0]      m_axis_tdata,   // [31:0] name_hash, [47:32] value_head,
	                                         // [63:48] value_finish, [64] quoted_value,
	                                         // [80:65] event_offset, [87:81] zero
	output logic [2:0]       m_axis_tuser,   // [2:0] result_kind
	output logic             m_axis_tlast    // at_text_end
);

	import kvcs_pkg::*;

	kvcs_cmd_t cmd;
	kvcs_sts_t sts;

	logic [OUT_HASH_W-1:0] res_hash;
	logic [OUT_OFF_W-1:0]  res_vbegin;
	logic [OUT_OFF_W-1:0]  res_vfinish;
	logic                  res_quoted;
	logic [OUT_OFF_W-1:0]  res_offset;

	kvcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kvcs_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_byte     (s_axis_tdata),
		.in_fin      (s_axis_tlast),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_kind    (m_axis_tuser),
		.out_hash    (res_hash),
		.out_vbegin  (res_vbegin),
		.out_vfinish (res_vfinish),
		.out_quoted  (res_quoted),
		.out_offset  (res_offset),
		.out_last    (m_axis_tlast)
	);

	// Pack the result word
	assign m_axis_tdata = {7'b0, res_offset, res_quoted, res_vfinish, res_vbegin, res_hash};

endmodule

`default_nettype wire
